/* design/ttt_pkg.sv */
package ttt_pkg;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_DELETE   = 2'd2,
        KIND_DISPATCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEL_EMPTY = 2'd1,
        ST_FULL     = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DELETE = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;

    localparam logic [4:0] NO_SLOT = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_tag;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [3:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [4:0] slot;
        logic [7:0] tag_out;
        logic [1:0] status;
        logic [1:0] error_code;
        logic       last;
    } rsp_t;

endpackage

/* design/task_timer_table_unit.sv */
// Task timer table: a queue of command requests (tick, add, delete,
// dispatch) in front of a table of NUM_SLOTS timer slots. Tick, add and
// dispatch walk the table one slot per cycle, dispatch holding while a
// response waits. Dispatch gives one response per pending slot, in slot
// order, last set on the final one, else one ST_NONE response. A two-entry
// request queue lets commands be pushed while the table walk is busy.
module task_timer_table_unit #(
    parameter int NUM_SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ttt_pkg::req_t req,
    output logic          empty,
    input  logic          pop,
    output ttt_pkg::rsp_t rsp
);
    import ttt_pkg::*;

    logic q_valid, q_take, rsp_valid;
    req_t q_req;

    ttt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
    );

    ttt_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_take(q_take), .rsp_valid(rsp_valid), .rsp(rsp),
        .rsp_take(pop)
    );

    assign empty = !rsp_valid;
endmodule

/* design/ttt_front.sv */
// Front end: two-entry request queue between the input port and the engine.
module ttt_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ttt_pkg::req_t req,
    output logic          q_valid,
    output ttt_pkg::req_t q_req,
    input  logic          q_take
);
    import ttt_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_req   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= req;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

/* design/ttt_engine.sv */
// Back end: walks the slot table one slot per cycle (dispatch holds while a response waits) and emits responses.
module ttt_engine #(
    parameter int NUM_SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ttt_pkg::req_t q_req,
    output logic          q_take,
    output logic          rsp_valid,
    output ttt_pkg::rsp_t rsp,
    input  logic          rsp_take
);
    import ttt_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW:0] LAST_IDX = (IW+1)'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

    logic [NUM_SLOTS-1:0] valid_reg, pend_reg;
    logic [7:0]           tag_reg   [NUM_SLOTS];
    logic [31:0]          delay_reg [NUM_SLOTS];
    logic [31:0]          period_reg[NUM_SLOTS];
    logic [1:0]           err_reg;

    state_t     state_reg;
    req_t       cur_reg;
    logic [IW:0] idx_reg;
    logic       found_reg;   // add found a free slot or dispatch emitted something
    logic       rv_reg;
    rsp_t       rsp_reg;

    logic [IW-1:0] i;
    logic          at_end;
    logic          out_free;

    assign i         = idx_reg[IW-1:0];
    assign at_end    = (idx_reg == LAST_IDX);
    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rv_reg || rsp_take;
    assign q_take    = (state_reg == S_IDLE) && q_valid;

    // one response at the end of tick/add/delete; dispatch one per pending slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pend_reg  <= '0;
            err_reg   <= ERR_NONE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (rv_reg && rsp_take) rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_req;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (q_req.kind == KIND_DELETE) ? S_OUT : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    unique case (kind_t'(cur_reg.kind))
                        KIND_TICK:
                        begin
                            if (valid_reg[i])
                            begin
                                if (delay_reg[i] == 32'd0)
                                begin
                                    if (!pend_reg[i])
                                    begin
                                        pend_reg[i] <= 1'b1;
                                        if (period_reg[i] != 32'd0)
                                            delay_reg[i] <= period_reg[i];
                                    end
                                end
                                else
                                begin
                                    delay_reg[i] <= delay_reg[i] - 32'd1;
                                end
                            end
                            if (at_end) state_reg <= S_OUT;
                            else        idx_reg   <= idx_reg + 1'b1;
                        end
                        KIND_ADD:
                        begin
                            if (!valid_reg[i])
                            begin
                                valid_reg[i]  <= 1'b1;
                                pend_reg[i]   <= 1'b0;
                                tag_reg[i]    <= cur_reg.task_tag;
                                delay_reg[i]  <= cur_reg.start_delay;
                                period_reg[i] <= cur_reg.repeat_period;
                                found_reg     <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                            else if (at_end)
                                state_reg <= S_OUT;
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                        KIND_DISPATCH:
                        begin
                            if (pend_reg[i])
                            begin
                                if (out_free)
                                begin
                                    rv_reg              <= 1'b1;
                                    rsp_reg.slot        <= 5'(idx_reg);
                                    rsp_reg.tag_out     <= tag_reg[i];
                                    rsp_reg.status      <= ST_OK;
                                    rsp_reg.error_code  <= err_reg;
                                    rsp_reg.last        <= ((pend_reg >> idx_reg) >> 1) == '0;
                                    found_reg           <= 1'b1;
                                    pend_reg[i]         <= 1'b0;
                                    if (period_reg[i] == 32'd0)
                                    begin
                                        valid_reg[i]  <= 1'b0;
                                        tag_reg[i]    <= 8'd0;
                                        delay_reg[i]  <= 32'd0;
                                    end
                                    if (at_end) state_reg <= S_IDLE;
                                    else        idx_reg   <= idx_reg + 1'b1;
                                end
                            end
                            else if (at_end)
                                state_reg <= found_reg ? S_IDLE : S_OUT;
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rv_reg          <= 1'b1;
                        rsp_reg.tag_out <= 8'd0;
                        rsp_reg.last    <= 1'b1;
                        rsp_reg.error_code <= err_reg;
                        rsp_reg.slot    <= NO_SLOT;
                        rsp_reg.status  <= ST_OK;
                        state_reg       <= S_IDLE;
                        unique case (kind_t'(cur_reg.kind))
                            KIND_TICK: ;
                            KIND_ADD:
                            begin
                                if (found_reg) rsp_reg.slot <= 5'(idx_reg);
                                else
                                begin
                                    rsp_reg.status     <= ST_FULL;
                                    rsp_reg.error_code <= ERR_FULL;
                                    err_reg            <= ERR_FULL;
                                end
                            end
                            KIND_DELETE:
                            begin
                                rsp_reg.slot <= {1'b0, cur_reg.slot_index};
                                if ({1'b0, cur_reg.slot_index} < 5'(NUM_SLOTS))
                                begin
                                    valid_reg[cur_reg.slot_index[IW-1:0]] <= 1'b0;
                                    pend_reg[cur_reg.slot_index[IW-1:0]]  <= 1'b0;
                                    tag_reg[cur_reg.slot_index[IW-1:0]]   <= 8'd0;
                                    delay_reg[cur_reg.slot_index[IW-1:0]] <= 32'd0;
                                    period_reg[cur_reg.slot_index[IW-1:0]] <= 32'd0;
                                end
                                if (!({1'b0, cur_reg.slot_index} < 5'(NUM_SLOTS)) ||
                                    !valid_reg[cur_reg.slot_index[IW-1:0]])
                                begin
                                    rsp_reg.status     <= ST_DEL_EMPTY;
                                    rsp_reg.error_code <= ERR_DELETE;
                                    err_reg            <= ERR_DELETE;
                                end
                            end
                            KIND_DISPATCH: rsp_reg.status <= ST_NONE;
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/ttt_checker.sv */
module ttt_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input ttt_pkg::rsp_t rsp
);
    import ttt_pkg::*;

    // a response waiting holds steady until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("response changed while stalled");

    // error code never reads as an undefined value
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.error_code != 2'd3))
        else $error("bad error code");

    // results with a status other than OK carry no tag and set last
    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != ST_OK) |-> (rsp.tag_out == 8'd0 && rsp.last))
        else $error("error result malformed");

    // full table or nothing-ready reports no slot
    a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (rsp.status == ST_FULL || rsp.status == ST_NONE))
            |-> (rsp.slot == NO_SLOT))
        else $error("slot must be none");
endmodule

bind task_timer_table_unit ttt_checker u_ttt_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .rsp(rsp)
);
